// ----- hw/rtl/sliding_window_sender_fast_retransmit_core_assert.svh -----
// assertion macros used by the sliding-window sender checker
`ifndef SLIDING_WINDOW_SENDER_FAST_RETRANSMIT_CORE_ASSERT_SVH
`define SLIDING_WINDOW_SENDER_FAST_RETRANSMIT_CORE_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define SWFR_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while dis is high
`define SWFR_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/swfr_pkg.sv -----
// shared constants and codes of the sliding-window sender
package swfr_pkg;

  // default geometry
  localparam int SWFR_WINDOW   = 4;
  localparam int SWFR_SEQ_BITS = 3;

  // fixed field widths
  localparam int TAG_W = 16;
  localparam int OP_W  = 2;
  localparam int TMR_W = 2;
  localparam int DUP_W = 2;

  // duplicate acks that trigger a fast resend
  localparam logic [DUP_W-1:0] DUP_LIMIT = 2'd3;

  // event kinds carried on in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  // retransmit timer commands
  typedef enum logic [TMR_W-1:0] {
    TMR_KEEP    = 2'd0,
    TMR_RESTART = 2'd1,
    TMR_STOP    = 2'd2
  } timer_cmd_t;

endpackage

// ----- hw/rtl/sliding_window_sender_fast_retransmit_core.sv -----
// a result word is loaded into the result register after its event word has passed the input register
// throughput: one event word per cycle while out_tready is high; each event updates the window
// state as it moves from the input register into the result register
// reset: synchronous, active low; empties the window, next and base seq to 0,
// last ack to all ones, duplicate count to 0; the tag store needs no clearing
module sliding_window_sender_fast_retransmit_core
  import swfr_pkg::*;
#(
  parameter int WINDOW   = SWFR_WINDOW,
  parameter int SEQ_BITS = SWFR_SEQ_BITS,
  localparam int ACK_W   = SEQ_BITS + 1,
  localparam int CNT_W   = $clog2(WINDOW + 1),
  localparam int IN_FW   = TAG_W + ACK_W + 1,
  localparam int IN_DW   = ((IN_FW + 7) / 8) * 8,
  localparam int OUT_FW  = 2 + SEQ_BITS + TAG_W + TMR_W + 2 + CNT_W,
  localparam int OUT_DW  = ((OUT_FW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // payload_tag, ack_num, ack_ok
  input  logic [OP_W-1:0]   in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // accepted, transmit, tx_seq, tx_tag,
                                        // timer_cmd, fast_resend, window_full,
                                        // in_flight
);

  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int CMP_W = (SEQ_BITS > CNT_W) ? SEQ_BITS : CNT_W;

  // input register
  logic                    s1_valid_r;
  logic [OP_W-1:0]         s1_op_r;
  logic [TAG_W-1:0]        s1_tag_r;
  logic signed [ACK_W-1:0] s1_ack_r;
  logic                    s1_ok_r;

  // window state; the oldest held seq always equals base_r, so no seq store
  logic [AW-1:0]       head_r,  head_nxt;
  logic [CNT_W-1:0]    held_r,  held_nxt;
  logic [SEQ_BITS-1:0] next_r,  next_nxt;
  logic [SEQ_BITS-1:0] base_r,  base_nxt;
  logic [ACK_W-1:0]    last_r,  last_nxt;
  logic [DUP_W-1:0]    dup_r,   dup_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r,  out_data_nxt;

  logic                fire;
  logic                full;
  logic [SEQ_BITS-1:0] new_base;
  logic [SEQ_BITS-1:0] span;
  logic [CMP_W-1:0]    span_x;
  logic [CMP_W-1:0]    held_x;
  logic [SUM_W-1:0]    head_sum;
  logic [SUM_W-1:0]    tail_sum;
  logic [AW-1:0]       head_adv;
  logic [AW-1:0]       tail;
  logic [TAG_W-1:0]    head_tag;
  logic [DUP_W-1:0]    dup_tmp;
  logic                wr_en;

  logic                r_accepted;
  logic                r_transmit;
  logic [SEQ_BITS-1:0] r_tx_seq;
  logic [TAG_W-1:0]    r_tx_tag;
  timer_cmd_t          r_timer;
  logic                r_fast;

  // handshake: the event in the input register moves on when the result slot frees
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= in_tuser;
      s1_tag_r <= in_tdata[TAG_W-1:0];
      s1_ack_r <= in_tdata[TAG_W +: ACK_W];
      s1_ok_r  <= in_tdata[TAG_W + ACK_W];
    end
  end

  // window arithmetic
  assign full     = (held_r >= CNT_W'(WINDOW));
  assign new_base = s1_ack_r[SEQ_BITS-1:0] + 1'b1;
  assign span     = new_base - base_r;
  assign span_x   = CMP_W'(span);
  assign held_x   = CMP_W'(held_r);
  assign head_sum = SUM_W'(head_r) + SUM_W'(span_x[CNT_W-1:0]);
  assign tail_sum = SUM_W'(head_r) + SUM_W'(held_r);
  assign head_adv = (head_sum >= SUM_W'(WINDOW)) ? AW'(head_sum - SUM_W'(WINDOW))
                                                 : AW'(head_sum);
  assign tail     = (tail_sum >= SUM_W'(WINDOW)) ? AW'(tail_sum - SUM_W'(WINDOW))
                                                 : AW'(tail_sum);

  // event handling
  always_comb begin
    head_nxt   = head_r;
    held_nxt   = held_r;
    next_nxt   = next_r;
    base_nxt   = base_r;
    last_nxt   = last_r;
    dup_nxt    = dup_r;
    dup_tmp    = '0;
    wr_en      = 1'b0;
    r_accepted = 1'b0;
    r_transmit = 1'b0;
    r_tx_seq   = '0;
    r_tx_tag   = '0;
    r_timer    = TMR_KEEP;
    r_fast     = 1'b0;
    if (fire) begin
      unique case (s1_op_r)
        OP_SEND: begin
          if (!full) begin
            wr_en      = 1'b1;
            r_accepted = 1'b1;
            r_transmit = 1'b1;
            r_tx_seq   = next_r;
            r_tx_tag   = s1_tag_r;
            if (base_r == next_r) begin
              r_timer = TMR_RESTART;
            end
            held_nxt = held_r + 1'b1;
            next_nxt = next_r + 1'b1;
          end
        end
        OP_ACK: begin
          // ignore acks on an empty window, bad checksums and stale numbers
          if ((held_r != '0) && s1_ok_r && (span_x <= held_x)) begin
            base_nxt = new_base;
            r_timer  = (new_base != next_r) ? TMR_RESTART : TMR_STOP;
            if (s1_ack_r == last_r) begin
              dup_tmp = dup_r + 1'b1;
            end else begin
              last_nxt = s1_ack_r;
              dup_tmp  = '0;
            end
            dup_nxt = dup_tmp;
            // third duplicate resends the oldest packet before sliding
            if (dup_tmp == DUP_LIMIT) begin
              r_transmit = 1'b1;
              r_fast     = 1'b1;
              r_tx_seq   = base_r;
              r_tx_tag   = head_tag;
              dup_nxt    = '0;
              r_timer    = TMR_RESTART;
            end
            head_nxt = head_adv;
            held_nxt = held_r - span_x[CNT_W-1:0];
          end
        end
        OP_TIMEOUT: begin
          if (held_r != '0) begin
            r_transmit = 1'b1;
            r_tx_seq   = base_r;
            r_tx_tag   = head_tag;
            r_timer    = TMR_RESTART;
          end else begin
            r_timer = TMR_STOP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tag store, read data tracks the head entry after each edge
  swfr_tag_mem #(
    .DEPTH (WINDOW),
    .AW    (AW),
    .DW    (TAG_W)
  ) u_tag_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (s1_tag_r),
    .rd_addr (head_nxt),
    .rd_data (head_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      held_r <= '0;
      next_r <= '0;
      base_r <= '0;
      last_r <= '1;
      dup_r  <= '0;
    end else begin
      head_r <= head_nxt;
      held_r <= held_nxt;
      next_r <= next_nxt;
      base_r <= base_nxt;
      last_r <= last_nxt;
      dup_r  <= dup_nxt;
    end
  end

  // result word
  assign out_data_nxt = OUT_DW'({held_nxt, (held_nxt >= CNT_W'(WINDOW)), r_fast, r_timer,
                                 r_tx_tag, r_tx_seq, r_transmit, r_accepted});
  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/swfr_tag_mem.sv -----
// payload tag store with one write port and a registered read with write bypass
module swfr_tag_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write, and read the entry at rd_addr as it stands after this edge
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/swfr_checker.sv -----
// port-level checks on the sliding-window sender result channel
`include "sliding_window_sender_fast_retransmit_core_assert.svh"

module swfr_checker
  import swfr_pkg::*;
#(
  parameter int WINDOW   = SWFR_WINDOW,
  parameter int SEQ_BITS = SWFR_SEQ_BITS,
  localparam int CNT_W   = $clog2(WINDOW + 1),
  localparam int OUT_FW  = 2 + SEQ_BITS + TAG_W + TMR_W + 2 + CNT_W,
  localparam int OUT_DW  = ((OUT_FW + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  localparam int TAG_LSB  = 2 + SEQ_BITS;
  localparam int TMR_LSB  = TAG_LSB + TAG_W;
  localparam int FAST_BIT = TMR_LSB + TMR_W;
  localparam int FULL_BIT = FAST_BIT + 1;
  localparam int CNT_LSB  = FULL_BIT + 1;

  logic             accepted;
  logic             transmit;
  logic [TMR_W-1:0] timer;
  logic             fast;
  logic             full;
  logic [CNT_W-1:0] cnt;

  // result fields
  assign accepted = out_tdata[0];
  assign transmit = out_tdata[1];
  assign timer    = out_tdata[TMR_LSB +: TMR_W];
  assign fast     = out_tdata[FAST_BIT];
  assign full     = out_tdata[FULL_BIT];
  assign cnt      = out_tdata[CNT_LSB +: CNT_W];

  `SWFR_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result word changed")
  `SWFR_ASSERT_NEXT(a_reset_idle, clk, 1'b0, !rst_n, !out_tvalid, "result valid right after reset")
  `SWFR_ASSERT_IMPLY(a_flight_cap, clk, !rst_n, out_tvalid, cnt <= CNT_W'(WINDOW), "in_flight above window size")
  `SWFR_ASSERT_IMPLY(a_full_match, clk, !rst_n, out_tvalid, full == (cnt == CNT_W'(WINDOW)), "window_full disagrees with in_flight")
  `SWFR_ASSERT_IMPLY(a_fast_restart, clk, !rst_n, out_tvalid && fast, transmit && !accepted && (timer == TMR_RESTART), "fast resend without transmit and timer restart")

endmodule

bind sliding_window_sender_fast_retransmit_core swfr_checker #(
  .WINDOW   (WINDOW),
  .SEQ_BITS (SEQ_BITS)
) u_swfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
